### hw/rtl/swk_pkg.sv
// Shared constants, types and helper functions for the swerve wheel kinematics block.
package swk_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);

  localparam int DW = 36;
  localparam int ZW = 32;
  localparam int MW = 31;
  localparam int PW = DW + MW;

  localparam int ZSH          = 20 - ANGLE_FRAC_BITS;
  localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int Z_HALF       = 180 << 20;

  localparam int KINV_Q30    = 652032874;
  localparam int DEG2RAD_Q32 = 74961321;
  localparam int MAG_EPS     = 655;
  localparam int TURN_LIMIT  = 240;
  localparam int WHEEL_LIMIT = 10000;

  // |a| / HALF_TURN as ((|a| >> QSH) * RECIP_45) >> RECIP_SH
  localparam int QSH      = ANGLE_FRAC_BITS + 2;
  localparam int RECIP_45 = 190887436;
  localparam int RECIP_SH = 33;

  localparam logic signed [MW-1:0] KINV_M    = MW'(KINV_Q30);
  localparam logic signed [MW-1:0] DEG2RAD_M = MW'(DEG2RAD_Q32);
  localparam logic signed [MW-1:0] RECIP_M   = MW'(RECIP_45);
  localparam logic signed [MW-1:0] FULL_M    = MW'(FULL_TURN);

  localparam logic signed [DW-1:0] HALF_D    = DW'(HALF_TURN);
  localparam logic signed [DW-1:0] FULL_D    = DW'(FULL_TURN);
  localparam logic signed [DW-1:0] QUARTER_D = DW'(QUARTER_TURN);
  localparam logic signed [ZW-1:0] Z_HALF_Z  = ZW'(Z_HALF);

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic                 neg;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 32'sd47185920;
      5'd1:  r = 32'sd27855475;
      5'd2:  r = 32'sd14718068;
      5'd3:  r = 32'sd7471121;
      5'd4:  r = 32'sd3750058;
      5'd5:  r = 32'sd1876857;
      5'd6:  r = 32'sd938658;
      5'd7:  r = 32'sd469357;
      5'd8:  r = 32'sd234682;
      5'd9:  r = 32'sd117342;
      5'd10: r = 32'sd58671;
      5'd11: r = 32'sd29335;
      5'd12: r = 32'sd14668;
      5'd13: r = 32'sd7334;
      5'd14: r = 32'sd3667;
      5'd15: r = 32'sd1833;
      5'd16: r = 32'sd917;
      5'd17: r = 32'sd458;
      5'd18: r = 32'sd229;
      5'd19: r = 32'sd115;
      5'd20: r = 32'sd57;
      5'd21: r = 32'sd29;
      5'd22: r = 32'sd14;
      5'd23: r = 32'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half away from zero
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] v,
                                                   input int unsigned s);
    logic [PW-1:0] a;
    logic [PW-1:0] r;
    a = v[PW-1] ? PW'(-v) : PW'(v);
    r = (a + (PW'(1) << (s - 1))) >> s;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [DW-1:0] wrap_half(input logic signed [DW-1:0] a);
    logic signed [DW-1:0] r;
    r = a;
    if (a > HALF_D) begin
      r = a - FULL_D;
    end else if (a < -HALF_D) begin
      r = a + FULL_D;
    end
    return r;
  endfunction

endpackage

### hw/rtl/swk_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation and vectoring modes.
module swk_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swk_pkg::cordic_cmd_t cmd,
  output swk_pkg::cordic_rsp_t rsp
);
  import swk_pkg::*;

  logic signed [DW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [STEP_W-1:0]    i_r;
  logic                 busy_r, done_r, vec_r, neg_r;

  logic signed [DW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic                 pos;

  always_comb begin
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    at  = atan_q20(5'(i_r));
    pos = vec_r ? y_r[DW-1] : !z_r[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        vec_r  <= cmd.vec;
        neg_r  <= cmd.neg;
        if (cmd.vec && cmd.x[DW-1]) begin
          x_r <= -cmd.x;
          y_r <= -cmd.y;
          z_r <= cmd.y[DW-1] ? -Z_HALF_Z : Z_HALF_Z;
        end else begin
          x_r <= cmd.x;
          y_r <= cmd.y;
          z_r <= cmd.z;
        end
      end else if (busy_r) begin
        if (pos) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.x    = neg_r ? -x_r : x_r;
    rsp.y    = neg_r ? -y_r : y_r;
    rsp.z    = z_r;
  end

endmodule

### hw/rtl/swerve_wheel_kinematics.sv
// Top level: sequencer, shared multiplier, steer state and APB register file.
// The single CORDIC unit runs seven passes per item, so items are handled one at a time.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register while the next item is taken.
// Reset (synchronous, rst_n low): registers to defaults, steer angles to 180 degrees.
module swerve_wheel_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] in_cmd_speed,
  input  logic signed [14:0] in_cmd_heading,
  input  logic signed [10:0] in_cmd_turn_rate,
  input  logic signed [14:0] in_posture_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [14:0] out_wheel_one_speed,
  output logic signed [31:0] out_wheel_one_steer,
  output logic signed [14:0] out_wheel_two_speed,
  output logic signed [31:0] out_wheel_two_steer,
  output logic signed [14:0] out_wheel_three_speed,
  output logic signed [31:0] out_wheel_three_steer,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T_MUL, S_T_ROT, S_T_WAIT, S_R_MUL1, S_R_MUL2, S_R_RND,
    S_W_KINV, S_W_ROT, S_W_ROTW, S_W_VECW, S_W_MAG, S_W_QMUL, S_W_DIR,
    S_W_NMUL, S_W_ADD, S_W_FLIP, S_W_STORE, S_DONE
  } state_t;

  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_BASE_RADIUS = 3'd1;
  localparam logic [2:0] REG_MOUNT_ONE   = 3'd2;
  localparam logic [2:0] REG_MOUNT_TWO   = 3'd3;
  localparam logic [2:0] REG_MOUNT_THREE = 3'd4;

  state_t state_r;

  logic [13:0]        speed_limit_r;
  logic [10:0]        base_radius_r;
  logic signed [14:0] mount1_r, mount2_r, mount3_r;

  logic [13:0]          v_r;
  logic signed [10:0]   om_r;
  logic signed [14:0]   head_r, post_r;
  logic [1:0]           w_r;
  logic signed [DW-1:0] tx_r, ty_r, rmag_r, vx_r, mag_r, dir_r, nf_r, n_r;
  logic signed [ZW-1:0] vz_r;
  logic                 flip_r;
  logic signed [PW-1:0] prod_r;
  logic [31:0]          steer_r [3];
  logic signed [14:0]   spd_r [3];
  logic                 out_valid_r;
  logic signed [14:0]   o_spd1_r, o_spd2_r, o_spd3_r;
  logic [31:0]          o_str1_r, o_str2_r, o_str3_r;

  cordic_cmd_t cmd;
  cordic_rsp_t rsp;

  swk_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  logic signed [DW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [DW-1:0] act, abs_act, mount_w, rot_ang, q_ang;
  logic                 rot_neg;
  logic                 wr_en;
  logic [2:0]           widx;

  assign wr_en    = psel && penable && pwrite;
  assign widx     = paddr[4:2];
  assign pready   = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    case (widx)
      REG_SPEED_LIMIT: prdata = 32'(speed_limit_r);
      REG_BASE_RADIUS: prdata = 32'(base_radius_r);
      REG_MOUNT_ONE:   prdata = 32'(unsigned'(mount1_r));
      REG_MOUNT_TWO:   prdata = 32'(unsigned'(mount2_r));
      REG_MOUNT_THREE: prdata = 32'(unsigned'(mount3_r));
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    act     = DW'($signed(steer_r[w_r]));
    abs_act = act[DW-1] ? -act : act;
    case (w_r)
      2'd0:    mount_w = DW'(mount1_r);
      2'd1:    mount_w = DW'(mount2_r);
      default: mount_w = DW'(mount3_r);
    endcase
    rot_ang = (state_r == S_T_ROT) ? wrap_half(DW'(head_r))
                                   : wrap_half(mount_w + DW'(post_r));
    rot_neg = 1'b0;
    q_ang   = rot_ang;
    if (rot_ang > QUARTER_D) begin
      q_ang   = rot_ang - HALF_D;
      rot_neg = 1'b1;
    end else if (rot_ang < -QUARTER_D) begin
      q_ang   = rot_ang + HALF_D;
      rot_neg = 1'b1;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_T_MUL: begin
        mul_a = $signed({{(DW-30){1'b0}}, v_r, 16'b0});
        mul_b = KINV_M;
      end
      S_R_MUL1: begin
        mul_a = DW'(om_r);
        mul_b = $signed(MW'(base_radius_r));
      end
      S_R_MUL2: begin
        mul_a = prod_r[DW-1:0];
        mul_b = DEG2RAD_M;
      end
      S_W_KINV: begin
        mul_a = rmag_r;
        mul_b = KINV_M;
      end
      S_W_MAG: begin
        mul_a = vx_r;
        mul_b = KINV_M;
      end
      S_W_QMUL: begin
        mul_a = abs_act >>> QSH;
        mul_b = RECIP_M;
      end
      S_W_NMUL: begin
        mul_a = n_r;
        mul_b = FULL_M;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.start = 1'b0;
    case (state_r)
      S_T_ROT, S_W_ROT: begin
        cmd.start = 1'b1;
        cmd.x     = DW'(rnd_shr(prod_r, 30));
        cmd.z     = ZW'(q_ang <<< ZSH);
        cmd.neg   = rot_neg;
      end
      S_W_ROTW: begin
        cmd.start = rsp.done;
        cmd.vec   = 1'b1;
        cmd.x     = tx_r + rsp.x;
        cmd.y     = ty_r + rsp.y;
      end
      default: cmd = '0;
    endcase
  end

  logic signed [DW-1:0] q1, nq, dsel, err, tflip, dlt, fin, spd;

  always_comb begin
    q1    = DW'(prod_r >>> RECIP_SH);
    nq    = q1 - (q1 >>> 1);
    dsel  = (mag_r > DW'(MAG_EPS)) ? DW'(rnd_shr(PW'(vz_r), ZSH)) : DW'(head_r);
    err   = wrap_half(dir_r - act);
    tflip = dir_r + HALF_D;
    if (tflip > nf_r + HALF_D) begin
      tflip = tflip - FULL_D;
    end else if (tflip < nf_r - HALF_D) begin
      tflip = tflip + FULL_D;
    end
    dlt = dir_r - act;
    fin = dir_r;
    if (dlt > HALF_D) begin
      fin = dir_r - FULL_D;
    end else if (dlt < -HALF_D) begin
      fin = dir_r + FULL_D;
    end
    spd = DW'(rnd_shr(PW'(mag_r), 16));
    if (spd > DW'(WHEEL_LIMIT)) begin
      spd = DW'(WHEEL_LIMIT);
    end
    if (flip_r) begin
      spd = -spd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      speed_limit_r <= 14'd4000;
      base_radius_r <= 11'd400;
      mount1_r      <= 15'sd0;
      mount2_r      <= 15'sd7680;
      mount3_r      <= -15'sd7680;
      for (int k = 0; k < 3; k++) begin
        steer_r[k] <= 32'(HALF_TURN);
      end
    end else begin
      prod_r <= mul_a * mul_b;
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        case (widx)
          REG_SPEED_LIMIT: speed_limit_r <= pwdata[13:0];
          REG_BASE_RADIUS: base_radius_r <= pwdata[10:0];
          REG_MOUNT_ONE:   mount1_r <= $signed(pwdata[14:0]);
          REG_MOUNT_TWO:   mount2_r <= $signed(pwdata[14:0]);
          REG_MOUNT_THREE: mount3_r <= $signed(pwdata[14:0]);
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v_r <= (in_cmd_speed > speed_limit_r) ? speed_limit_r : in_cmd_speed;
            if (in_cmd_turn_rate > 11'(TURN_LIMIT)) begin
              om_r <= 11'(TURN_LIMIT);
            end else if (in_cmd_turn_rate < -11'(TURN_LIMIT)) begin
              om_r <= -11'(TURN_LIMIT);
            end else begin
              om_r <= in_cmd_turn_rate;
            end
            head_r  <= in_cmd_heading;
            post_r  <= in_posture_angle;
            w_r     <= 2'd0;
            state_r <= S_T_MUL;
          end
        end
        S_T_MUL:  state_r <= S_T_ROT;
        S_T_ROT:  state_r <= S_T_WAIT;
        S_T_WAIT: begin
          if (rsp.done) begin
            tx_r    <= rsp.x;
            ty_r    <= rsp.y;
            state_r <= S_R_MUL1;
          end
        end
        S_R_MUL1: state_r <= S_R_MUL2;
        S_R_MUL2: state_r <= S_R_RND;
        S_R_RND: begin
          rmag_r  <= DW'(rnd_shr(prod_r, 16));
          state_r <= S_W_KINV;
        end
        S_W_KINV: state_r <= S_W_ROT;
        S_W_ROT:  state_r <= S_W_ROTW;
        S_W_ROTW: begin
          if (rsp.done) begin
            state_r <= S_W_VECW;
          end
        end
        S_W_VECW: begin
          if (rsp.done) begin
            vx_r    <= rsp.x;
            vz_r    <= rsp.z;
            state_r <= S_W_MAG;
          end
        end
        S_W_MAG: state_r <= S_W_QMUL;
        S_W_QMUL: begin
          mag_r   <= DW'(rnd_shr(prod_r, 30));
          state_r <= S_W_DIR;
        end
        S_W_DIR: begin
          n_r     <= act[DW-1] ? -nq : nq;
          dir_r   <= wrap_half(dsel - DW'(post_r));
          state_r <= S_W_NMUL;
        end
        S_W_NMUL: state_r <= S_W_ADD;
        S_W_ADD: begin
          nf_r    <= prod_r[DW-1:0];
          dir_r   <= dir_r + prod_r[DW-1:0];
          state_r <= S_W_FLIP;
        end
        S_W_FLIP: begin
          if (err > QUARTER_D || err < -QUARTER_D) begin
            flip_r <= 1'b1;
            dir_r  <= tflip;
          end else begin
            flip_r <= 1'b0;
          end
          state_r <= S_W_STORE;
        end
        S_W_STORE: begin
          steer_r[w_r] <= fin[31:0];
          spd_r[w_r]   <= 15'(spd);
          if (w_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            w_r     <= w_r + 2'd1;
            state_r <= S_W_KINV;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            o_spd1_r    <= spd_r[0];
            o_spd2_r    <= spd_r[1];
            o_spd3_r    <= spd_r[2];
            o_str1_r    <= steer_r[0];
            o_str2_r    <= steer_r[1];
            o_str3_r    <= steer_r[2];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_wheel_one_speed   = o_spd1_r;
  assign out_wheel_two_speed   = o_spd2_r;
  assign out_wheel_three_speed = o_spd3_r;
  assign out_wheel_one_steer   = $signed(o_str1_r);
  assign out_wheel_two_steer   = $signed(o_str2_r);
  assign out_wheel_three_steer = $signed(o_str3_r);

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_T_WAIT || state_r == S_W_ROTW || state_r == S_W_VECW))
    else $error("cordic result with no waiting state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_T_MUL))
    else $error("accepted transfer did not start sequence");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

  a_no_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.start)
    else $error("cordic started while idle");

endmodule
